FILE: rtl/jrd_pkg.sv
// Shared types and constants for the joystick radial deadzone block.
package jrd_pkg;

    localparam int RAW_W    = 11;
    localparam int SCALE_W  = 5;
    localparam int SC_W     = 15;
    localparam int D_W      = 17;
    localparam int ABS_W    = 16;
    localparam int SQ_W     = 32;
    localparam int MAG_W    = 16;
    localparam int DZ_W     = 14;
    localparam int LIM_W    = 14;
    localparam int GAIN_W   = 10;
    localparam int INV_W    = 2;
    localparam int OUT_W    = 15;
    localparam int STAT_W   = 2;
    localparam int DIV_W    = 32;
    localparam int DIVR_W   = 16;
    localparam int DCNT_W   = 5;
    localparam int RCNT_W   = 4;
    localparam int SAT_W    = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int PCT_SHIFT = 38;

    localparam logic [9:0]        HALF_RANGE   = 10'd900;
    // ceil(2^38 / 100): exact floor division by 100 for any 32-bit dividend
    localparam logic [DIV_W-1:0]  PCT_RECIP    = 32'd2748779070;
    localparam logic [GAIN_W-1:0] TUNE_DEFAULT = GAIN_W'(180);
    localparam logic [SCALE_W-1:0] SCALE_MAX   = SCALE_W'(16);
    // above this magnitude any nonzero gain already saturates at the limit
    localparam logic [SAT_W-1:0]  SAT_MAG      = SAT_W'(1440100);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_X_FAIL = 2'd1,
        STAT_Y_FAIL = 2'd2
    } stat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE = 3'd0,
        CFG_SCALE    = 3'd1,
        CFG_TPOS_X   = 3'd2,
        CFG_TNEG_X   = 3'd3,
        CFG_TPOS_Y   = 3'd4,
        CFG_TNEG_Y   = 3'd5,
        CFG_INVERT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DZ_W-1:0]    deadzone;
        logic [SCALE_W-1:0] scale_factor;
        logic [GAIN_W-1:0]  tune_pos_x;
        logic [GAIN_W-1:0]  tune_neg_x;
        logic [GAIN_W-1:0]  tune_pos_y;
        logic [GAIN_W-1:0]  tune_neg_y;
        logic [INV_W-1:0]   invert_mask;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SQUARE,
        OP_RT_INIT,
        OP_RT_STEP,
        OP_DZ,
        OP_SEL,
        OP_MUL_LIM,
        OP_DIV_MAG,
        OP_MUL_SPAN,
        OP_DIV_SPAN,
        OP_MUL_GAIN,
        OP_DIV_PCT,
        OP_FINISH,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;
    } dp_cmd_t;

    typedef struct packed {
        logic fail;
        logic rt_last;
        logic dz_on;
        logic gain_on;
        logic div_done;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_SQUARE,
        S_RT_INIT,
        S_RT,
        S_DZ,
        S_SEL,
        S_MUL_LIM,
        S_DIV_MAG,
        S_WAIT_MAG,
        S_MUL_SPAN,
        S_DIV_SPAN,
        S_WAIT_SPAN,
        S_GAIN,
        S_DIV_PCT,
        S_FINISH,
        S_OUT
    } ctrl_state_t;

endpackage

FILE: rtl/jrd_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module jrd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [jrd_pkg::DIV_W-1:0]   dividend,
    input  logic [jrd_pkg::DIVR_W-1:0]  divisor,
    output logic                        done,
    output logic [jrd_pkg::DIV_W-1:0]   quotient
);
    import jrd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DIVR_W-1:0]   dvs_reg, dvs_next;
    logic [DIVR_W:0]     rem_reg, rem_next;
    logic [DIVR_W:0]     rem_shift;

    assign rem_shift = {rem_reg[DIVR_W-1:0], quo_reg[DIV_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = rem_shift - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> cnt_reg == '0)
        else $error("divider stopped early");

endmodule

FILE: rtl/jrd_ctrl.sv
// Sequencer for the radial deadzone datapath and the handshakes.
module jrd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  jrd_pkg::dp_stat_t stat,
    output jrd_pkg::dp_cmd_t  cmd
);
    import jrd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        axis_reg, axis_next;
    logic        mvalid_reg, mvalid_next;
    logic        out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_DIFF;
            S_DIFF:      state_next = stat.fail ? S_OUT : S_SQUARE;
            S_SQUARE:    state_next = S_RT_INIT;
            S_RT_INIT:   state_next = S_RT;
            S_RT:        if (stat.rt_last) state_next = S_DZ;
            S_DZ: begin
                state_next = S_SEL;
                axis_next  = 1'b0;
            end
            S_SEL:       state_next = stat.dz_on ? S_MUL_LIM : S_GAIN;
            S_MUL_LIM:   state_next = S_DIV_MAG;
            S_DIV_MAG:   state_next = S_WAIT_MAG;
            S_WAIT_MAG:  if (stat.div_done) state_next = S_MUL_SPAN;
            S_MUL_SPAN:  state_next = S_DIV_SPAN;
            S_DIV_SPAN:  state_next = S_WAIT_SPAN;
            S_WAIT_SPAN: if (stat.div_done) state_next = S_GAIN;
            S_GAIN:      state_next = stat.gain_on ? S_DIV_PCT : S_FINISH;
            S_DIV_PCT:   state_next = S_FINISH;
            S_FINISH: begin
                if (axis_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SEL;
                    axis_next  = 1'b1;
                end
            end
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        cmd.axis = axis_reg;
        s_tready = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            S_DIFF:      cmd.op = OP_DIFF;
            S_SQUARE:    cmd.op = OP_SQUARE;
            S_RT_INIT:   cmd.op = OP_RT_INIT;
            S_RT:        cmd.op = OP_RT_STEP;
            S_DZ:        cmd.op = OP_DZ;
            S_SEL:       cmd.op = OP_SEL;
            S_MUL_LIM:   cmd.op = OP_MUL_LIM;
            S_DIV_MAG:   cmd.op = OP_DIV_MAG;
            S_MUL_SPAN:  cmd.op = OP_MUL_SPAN;
            S_DIV_SPAN:  cmd.op = OP_DIV_SPAN;
            S_GAIN:      if (stat.gain_on) cmd.op = OP_MUL_GAIN;
            S_DIV_PCT:   cmd.op = OP_DIV_PCT;
            S_FINISH:    cmd.op = OP_FINISH;
            S_OUT: begin
                if (out_free) begin
                    cmd.op      = OP_PUSH;
                    mvalid_next = 1'b1;
                end
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            axis_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |-> out_free)
        else $error("result overwritten");
    a_wait_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> state_reg == S_WAIT_MAG || state_reg == S_WAIT_SPAN)
        else $error("division finished out of sequence");

endmodule

FILE: rtl/jrd_dp.sv
// Datapath: scaling, centre, root, radial rescale, gain, clamp, invert.
module jrd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  jrd_pkg::cfg_t                 cfg,
    input  jrd_pkg::dp_cmd_t              cmd,
    output jrd_pkg::dp_stat_t             stat,
    input  logic [jrd_pkg::RAW_W-1:0]     raw_x,
    input  logic [jrd_pkg::RAW_W-1:0]     raw_y,
    input  logic                          calibrate,
    output logic signed [jrd_pkg::OUT_W-1:0] out_x,
    output logic signed [jrd_pkg::OUT_W-1:0] out_y,
    output logic [jrd_pkg::STAT_W-1:0]    status
);
    import jrd_pkg::*;

    logic [SC_W-1:0]   centre_x_reg, centre_y_reg;
    logic [SC_W-1:0]   sx_reg, sy_reg;
    logic [LIM_W-1:0]  limit_reg;
    stat_t             stat_reg;
    logic [ABS_W-1:0]  ax_reg, ay_reg;
    logic              nx_reg, ny_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   rt_val_reg;
    logic [MAG_W+1:0]  rt_rem_reg;
    logic [MAG_W-1:0]  rt_root_reg;
    logic [RCNT_W-1:0] rt_cnt_reg;
    logic              dz_on_reg;
    logic [DIV_W-1:0]  cur_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  prod_reg;
    logic signed [OUT_W-1:0] res_x_reg, res_y_reg;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg;
    stat_t             out_stat_reg;

    logic [SCALE_W-1:0] scale;
    logic [SC_W-1:0]    sx, sy;
    logic signed [D_W-1:0] dx, dy;
    logic [MAG_W+3:0]   rem_shift;
    logic [MAG_W+3:0]   rt_test;
    logic               dz_active, force_zero;
    logic [GAIN_W-1:0]  gain;
    logic [SAT_W-1:0]   sat_mag;
    logic [LIM_W-1:0]   clamp_mag;
    logic signed [OUT_W-1:0] fin_val;
    logic [2*DIV_W-1:0] pct_prod;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    assign scale = (cfg.scale_factor > SCALE_MAX) ? SCALE_MAX : cfg.scale_factor;
    assign sx = SC_W'(raw_x * scale);
    assign sy = SC_W'(raw_y * scale);
    assign dx = $signed({2'b00, sx_reg}) - $signed({2'b00, centre_x_reg});
    assign dy = $signed({2'b00, sy_reg}) - $signed({2'b00, centre_y_reg});

    assign rem_shift = {rt_rem_reg, rt_val_reg[SQ_W-1 -: 2]};
    assign rt_test   = {2'b00, rt_root_reg, 2'b01};

    assign dz_active  = cfg.deadzone != '0;
    assign force_zero = dz_active && ((rt_root_reg <= {2'b00, cfg.deadzone})
                                      || (cfg.deadzone >= limit_reg));

    always_comb begin
        if (cmd.axis) gain = neg_reg ? cfg.tune_neg_y : cfg.tune_pos_y;
        else          gain = neg_reg ? cfg.tune_neg_x : cfg.tune_pos_x;
    end

    assign sat_mag   = (cur_reg > DIV_W'(SAT_MAG)) ? SAT_MAG : cur_reg[SAT_W-1:0];
    assign clamp_mag = (cur_reg > DIV_W'(limit_reg)) ? limit_reg : cur_reg[LIM_W-1:0];
    assign fin_val   = (neg_reg ^ cfg.invert_mask[cmd.axis])
                       ? -$signed({1'b0, clamp_mag}) : $signed({1'b0, clamp_mag});
    assign pct_prod  = (2*DIV_W)'(prod_reg) * (2*DIV_W)'(PCT_RECIP);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = '0;
        case (cmd.op)
            OP_DIV_MAG: begin
                div_start   = 1'b1;
                div_divisor = rt_root_reg;
            end
            OP_DIV_SPAN: begin
                div_start   = 1'b1;
                div_divisor = DIVR_W'(limit_reg - cfg.deadzone);
            end
            default:    div_start = 1'b0;
        endcase
    end

    jrd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            stat_reg     <= STAT_OK;
            out_stat_reg <= STAT_OK;
            rt_cnt_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    sx_reg    <= sx;
                    sy_reg    <= sy;
                    limit_reg <= LIM_W'(HALF_RANGE * scale);
                    res_x_reg <= '0;
                    res_y_reg <= '0;
                    if (calibrate && sx != '0) centre_x_reg <= sx;
                    if (calibrate && sy != '0) centre_y_reg <= sy;
                    if (sx == '0)      stat_reg <= STAT_X_FAIL;
                    else if (sy == '0) stat_reg <= STAT_Y_FAIL;
                    else               stat_reg <= STAT_OK;
                end
                OP_DIFF: begin
                    ax_reg <= dx[D_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
                    ay_reg <= dy[D_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
                    nx_reg <= dx[D_W-1];
                    ny_reg <= dy[D_W-1];
                end
                OP_SQUARE: sq_reg <= (ax_reg * ax_reg) + (ay_reg * ay_reg);
                OP_RT_INIT: begin
                    rt_val_reg  <= sq_reg;
                    rt_rem_reg  <= '0;
                    rt_root_reg <= '0;
                    rt_cnt_reg  <= '0;
                end
                OP_RT_STEP: begin
                    if (rem_shift >= rt_test) begin
                        rt_rem_reg  <= (MAG_W+2)'(rem_shift - rt_test);
                        rt_root_reg <= {rt_root_reg[MAG_W-2:0], 1'b1};
                    end else begin
                        rt_rem_reg  <= rem_shift[MAG_W+1:0];
                        rt_root_reg <= {rt_root_reg[MAG_W-2:0], 1'b0};
                    end
                    rt_val_reg <= {rt_val_reg[SQ_W-3:0], 2'b00};
                    rt_cnt_reg <= rt_cnt_reg + 1'b1;
                end
                OP_DZ: begin
                    dz_on_reg <= dz_active && !force_zero;
                    if (force_zero) begin
                        ax_reg <= '0;
                        ay_reg <= '0;
                    end
                end
                OP_SEL: begin
                    cur_reg <= DIV_W'(cmd.axis ? ay_reg : ax_reg);
                    neg_reg <= cmd.axis ? ny_reg : nx_reg;
                end
                OP_MUL_LIM:  prod_reg <= DIV_W'(limit_reg * cur_reg[ABS_W-1:0]);
                OP_MUL_SPAN: prod_reg <= DIV_W'(cur_reg[LIM_W:0]
                                                * (rt_root_reg - MAG_W'(cfg.deadzone)));
                OP_MUL_GAIN: prod_reg <= DIV_W'(sat_mag * gain);
                OP_DIV_PCT:  cur_reg  <= DIV_W'(pct_prod[2*DIV_W-1:PCT_SHIFT]);
                OP_FINISH: begin
                    if (cmd.axis) res_y_reg <= fin_val;
                    else          res_x_reg <= fin_val;
                end
                OP_PUSH: begin
                    out_x_reg    <= res_x_reg;
                    out_y_reg    <= res_y_reg;
                    out_stat_reg <= stat_reg;
                end
                default: ;
            endcase
            if (div_done) cur_reg <= div_quo;
        end
    end

    assign stat.fail     = stat_reg != STAT_OK;
    assign stat.rt_last  = rt_cnt_reg == '1;
    assign stat.dz_on    = dz_on_reg;
    assign stat.gain_on  = gain != '0 && cur_reg != '0;
    assign stat.div_done = div_done;

    assign out_x  = out_x_reg;
    assign out_y  = out_y_reg;
    assign status = out_stat_reg;

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_DIV_MAG |-> rt_root_reg != '0)
        else $error("divide by zero magnitude");
    a_span_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_DIV_SPAN |-> limit_reg > cfg.deadzone)
        else $error("deadzone span not positive");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH && stat_reg != STAT_OK |-> res_x_reg == '0 && res_y_reg == '0)
        else $error("failed request carries data");

endmodule

FILE: rtl/joystick_radial_deadzone.sv
// Top level: config registers, controller and datapath.
// One request in, one result out. A request with a zero scaled reading
// goes from the difference step straight to the output; a good one runs
// 16 square-root steps, then per axis up to two divisions on a shared
// bit-serial divider, with the percent gain done by a reciprocal
// multiply. Config writes must only happen while no request is in
// flight.
module joystick_radial_deadzone (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // raw_x, raw_y
    input  logic                               s_tuser,   // calibrate
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // out_x, out_y
    output logic [jrd_pkg::STAT_W-1:0]         m_tuser,   // status
    input  logic                               cfg_wr_en,
    input  logic [jrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import jrd_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic signed [OUT_W-1:0] out_x, out_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone     <= '0;
            cfg_reg.scale_factor <= SCALE_W'(1);
            cfg_reg.tune_pos_x   <= TUNE_DEFAULT;
            cfg_reg.tune_neg_x   <= TUNE_DEFAULT;
            cfg_reg.tune_pos_y   <= TUNE_DEFAULT;
            cfg_reg.tune_neg_y   <= TUNE_DEFAULT;
            cfg_reg.invert_mask  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEADZONE: cfg_reg.deadzone     <= cfg_wdata[DZ_W-1:0];
                CFG_SCALE:    cfg_reg.scale_factor <= cfg_wdata[SCALE_W-1:0];
                CFG_TPOS_X:   cfg_reg.tune_pos_x   <= cfg_wdata[GAIN_W-1:0];
                CFG_TNEG_X:   cfg_reg.tune_neg_x   <= cfg_wdata[GAIN_W-1:0];
                CFG_TPOS_Y:   cfg_reg.tune_pos_y   <= cfg_wdata[GAIN_W-1:0];
                CFG_TNEG_Y:   cfg_reg.tune_neg_y   <= cfg_wdata[GAIN_W-1:0];
                CFG_INVERT:   cfg_reg.invert_mask  <= cfg_wdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    jrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jrd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .raw_x     (s_tdata[RAW_W-1:0]),
        .raw_y     (s_tdata[2*RAW_W-1:RAW_W]),
        .calibrate (s_tuser),
        .out_x     (out_x),
        .out_y     (out_y),
        .status    (m_tuser)
    );

    assign m_tdata = {2'b00, out_y, out_x};

    a_fail_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
        else $error("failed result carries data");
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[14:0]) >= -15'sd14400
                     && $signed(m_tdata[14:0]) <= 15'sd14400)
        else $error("x output outside limit");
    a_stat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == STAT_OK || m_tuser == STAT_X_FAIL
                     || m_tuser == STAT_Y_FAIL)
        else $error("bad status code");

endmodule
